/* rtl/rir_pkg.sv */
// Shared constants, types and blend arithmetic for the image resize interpolator.
`timescale 1ns / 1ps
`default_nettype none

package rir_pkg;

    localparam int MAX_SRC_WIDTH  = 256;
    localparam int MAX_SRC_HEIGHT = 256;
    localparam int FRAC_BITS      = 16;

    localparam int COL_BITS  = $clog2(MAX_SRC_WIDTH);
    localparam int ROW_BITS  = $clog2(MAX_SRC_HEIGHT);
    localparam int SZ_BITS   = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
    localparam int IDX_BITS  = 12;
    localparam int DST_BITS  = 13;
    localparam int SRC_BITS  = 9;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 3;

    // quotient of the coordinate divide and the product feeding it
    localparam int Q_BITS    = SZ_BITS + FRAC_BITS;
    localparam int PROD_BITS = IDX_BITS + SZ_BITS;

    localparam int BANK_ADDR_BITS = (ROW_BITS - 1) + (COL_BITS - 1);
    localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
    localparam int NUM_BANKS      = 4;

    // edges from input transfer to result strobe
    localparam int LATENCY = Q_BITS + 5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INTERP_MODE = 3'd4;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef logic [31:0] pixel_t;

    typedef struct packed {
        logic                is_read;
        logic                in_range;
        logic                wr_ok;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        pixel_t              pix;
    } item_t;

    // p*(1-f) + q*f, truncated back to 8 bits
    function automatic logic [7:0] blend(input logic [7:0] p, input logic [7:0] q,
                                         input logic [FRAC_BITS-1:0] f);
        logic [FRAC_BITS:0]   inv;
        logic [FRAC_BITS+9:0] s;
        inv = (FRAC_BITS+1)'(1) << FRAC_BITS;
        inv = inv - {1'b0, f};
        s   = (FRAC_BITS+10)'(p) * (FRAC_BITS+10)'(inv)
            + (FRAC_BITS+10)'(q) * (FRAC_BITS+10)'(f);
        return s[FRAC_BITS+7:FRAC_BITS];
    endfunction

endpackage

`default_nettype wire

/* rtl/rir_ram.sv */
// One bank of the frame store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rir_ram (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [rir_pkg::BANK_ADDR_BITS-1:0] waddr,
    input  wire rir_pkg::pixel_t                    wdata,
    input  wire logic [rir_pkg::BANK_ADDR_BITS-1:0] raddr,
    output rir_pkg::pixel_t                         rdata
);
    import rir_pkg::*;

    pixel_t mem [BANK_DEPTH];
    pixel_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/rir_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, for one coordinate axis.
`timescale 1ns / 1ps
`default_nettype none

module rir_div_pipe (
    input  wire logic                          clk,
    input  wire logic [rir_pkg::PROD_BITS-1:0] prod,
    input  wire logic [rir_pkg::DST_BITS-1:0]  divisor,
    output logic      [rir_pkg::Q_BITS-1:0]    quot
);
    import rir_pkg::*;

    logic [DST_BITS-1:0] rem_reg  [Q_BITS];
    logic [Q_BITS-1:0]   low_reg  [Q_BITS];
    logic [Q_BITS-1:0]   quo_reg  [Q_BITS];
    logic [DST_BITS-1:0] rem_in   [Q_BITS];
    logic [Q_BITS-1:0]   low_in   [Q_BITS];
    logic [Q_BITS-1:0]   quo_in   [Q_BITS];
    logic [DST_BITS:0]   trial    [Q_BITS];
    logic                ge       [Q_BITS];
    logic [DST_BITS-1:0] rem_next [Q_BITS];
    logic [Q_BITS-1:0]   low_next [Q_BITS];
    logic [Q_BITS-1:0]   quo_next [Q_BITS];

    // one compare and subtract per stage, dividend shifted in from the top
    always_comb
    begin
        for (int k = 0; k < Q_BITS; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = DST_BITS'(prod >> SZ_BITS);
                low_in[k] = {prod[SZ_BITS-1:0], {FRAC_BITS{1'b0}}};
                quo_in[k] = '0;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                low_in[k] = low_reg[k-1];
                quo_in[k] = quo_reg[k-1];
            end
            trial[k]    = {rem_in[k], low_in[k][Q_BITS-1]};
            ge[k]       = (trial[k] >= {1'b0, divisor});
            rem_next[k] = ge[k] ? DST_BITS'(trial[k] - {1'b0, divisor})
                                : trial[k][DST_BITS-1:0];
            low_next[k] = low_in[k] << 1;
            quo_next[k] = {quo_in[k][Q_BITS-2:0], ge[k]};
        end
    end

    // advance every stage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < Q_BITS; k++)
        begin
            rem_reg[k] <= rem_next[k];
            low_reg[k] <= low_next[k];
            quo_reg[k] <= quo_next[k];
        end
    end

    assign quot = quo_reg[Q_BITS-1];

endmodule

`default_nettype wire

/* rtl/image_resize_interpolator.sv */
// Top level of the image resize interpolator: frame store, coordinate pipeline, blend.
//
// Usage: items enter on start while busy is low; busy is never raised, so one item
// may be transferred every clock cycle. req_type low writes in_blue..in_alpha into
// the source frame store at (row, col); writes outside the store are dropped and no
// write gives a result. req_type high reads destination pixel (row, col): after the
// transfer, strobe is high for one cycle with out_blue..out_alpha and range_error.
// An out-of-range read returns zero with range_error set. Throughput is one item per
// cycle, sustained; the latency is set by the 24-stage coordinate divider (one
// quotient bit per stage) plus input, neighbour-select, store read and two blend
// stages. Four neighbours are read in one cycle from four store banks split by row
// and column parity.
// Writes reach the store at the same stage where reads sample it, so program order
// holds. Configuration (cfg_we, cfg_index, cfg_data) is taken at once and must only
// change while no read is in flight. Reset clears the pipeline valid bits and
// loads the register defaults; the frame store content is undefined until written.
// The receiver cannot stall: each result stands for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module image_resize_interpolator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              req_type,
    input  wire logic [rir_pkg::IDX_BITS-1:0]      row,
    input  wire logic [rir_pkg::IDX_BITS-1:0]      col,
    input  wire logic [7:0]                        in_blue,
    input  wire logic [7:0]                        in_green,
    input  wire logic [7:0]                        in_red,
    input  wire logic [7:0]                        in_alpha,
    input  wire logic                              cfg_we,
    input  wire logic [rir_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [rir_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output logic                                   strobe,
    output logic [7:0]                             out_blue,
    output logic [7:0]                             out_green,
    output logic [7:0]                             out_red,
    output logic [7:0]                             out_alpha,
    output logic                                   range_error
);
    import rir_pkg::*;

    // configuration registers
    logic [SRC_BITS-1:0] src_width_reg, src_height_reg;
    logic [DST_BITS-1:0] dst_width_reg, dst_height_reg;
    logic                mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_BITS'(256);
            src_height_reg <= SRC_BITS'(256);
            dst_width_reg  <= DST_BITS'(256);
            dst_height_reg <= DST_BITS'(256);
            mode_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:   src_width_reg  <= cfg_data[SRC_BITS-1:0];
                CFG_SRC_HEIGHT:  src_height_reg <= cfg_data[SRC_BITS-1:0];
                CFG_DST_WIDTH:   dst_width_reg  <= cfg_data[DST_BITS-1:0];
                CFG_DST_HEIGHT:  dst_height_reg <= cfg_data[DST_BITS-1:0];
                CFG_INTERP_MODE: mode_reg       <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // effective sizes, held as size minus one
    logic [SZ_BITS-1:0]  sw_m1, sh_m1;
    logic [DST_BITS-1:0] dw_m1, dh_m1;

    always_comb
    begin
        if (src_width_reg == '0)
            sw_m1 = '0;
        else if (int'(src_width_reg) > MAX_SRC_WIDTH)
            sw_m1 = SZ_BITS'(MAX_SRC_WIDTH - 1);
        else
            sw_m1 = SZ_BITS'(src_width_reg - SRC_BITS'(1));
        if (src_height_reg == '0)
            sh_m1 = '0;
        else if (int'(src_height_reg) > MAX_SRC_HEIGHT)
            sh_m1 = SZ_BITS'(MAX_SRC_HEIGHT - 1);
        else
            sh_m1 = SZ_BITS'(src_height_reg - SRC_BITS'(1));
        dw_m1 = (dst_width_reg == '0)  ? '0 : dst_width_reg - DST_BITS'(1);
        dh_m1 = (dst_height_reg == '0) ? '0 : dst_height_reg - DST_BITS'(1);
    end

    assign busy = 1'b0;

    // capture the transfer
    item_t in_item;
    logic  vld1_reg;
    item_t item1_reg;

    always_comb
    begin
        in_item.is_read  = req_type;
        in_item.in_range = ({1'b0, row} <= dh_m1) && ({1'b0, col} <= dw_m1);
        in_item.wr_ok    = (int'(row) < MAX_SRC_HEIGHT) && (int'(col) < MAX_SRC_WIDTH);
        in_item.row      = row;
        in_item.col      = col;
        in_item.pix      = {in_alpha, in_red, in_green, in_blue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld1_reg <= 1'b0;
        else
            vld1_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        item1_reg <= in_item;
    end

    // coordinate dividers
    logic [PROD_BITS-1:0] prod_y, prod_x;
    logic [Q_BITS-1:0]    quot_y, quot_x;

    assign prod_y = PROD_BITS'(item1_reg.row) * PROD_BITS'(sh_m1);
    assign prod_x = PROD_BITS'(item1_reg.col) * PROD_BITS'(sw_m1);

    rir_div_pipe u_div_y (
        .clk     (clk),
        .prod    (prod_y),
        .divisor (dh_m1),
        .quot    (quot_y)
    );

    rir_div_pipe u_div_x (
        .clk     (clk),
        .prod    (prod_x),
        .divisor (dw_m1),
        .quot    (quot_x)
    );

    // carry items alongside the divider stages
    logic  vld_d_reg  [Q_BITS];
    item_t item_d_reg [Q_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < Q_BITS; k++)
                vld_d_reg[k] <= 1'b0;
        end
        else
        begin
            vld_d_reg[0] <= vld1_reg;
            for (int k = 1; k < Q_BITS; k++)
                vld_d_reg[k] <= vld_d_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        item_d_reg[0] <= item1_reg;
        for (int k = 1; k < Q_BITS; k++)
            item_d_reg[k] <= item_d_reg[k-1];
    end

    // round or floor, clamp and pick the neighbours
    logic [Q_BITS-1:0]    oy, ox;
    logic [SZ_BITS:0]     ry, rx;
    logic [ROW_BITS-1:0]  fy, cy, sh_last;
    logic [COL_BITS-1:0]  fx, cx, sw_last;
    logic [FRAC_BITS-1:0] wy, wx;

    always_comb
    begin
        oy = (dh_m1 == '0) ? '0 : quot_y;
        ox = (dw_m1 == '0) ? '0 : quot_x;
        if (mode_reg)
        begin
            ry = (SZ_BITS+1)'(oy >> FRAC_BITS);
            rx = (SZ_BITS+1)'(ox >> FRAC_BITS);
        end
        else
        begin
            ry = (SZ_BITS+1)'(({1'b0, oy} + (Q_BITS+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
            rx = (SZ_BITS+1)'(({1'b0, ox} + (Q_BITS+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        end
        sh_last = ROW_BITS'(sh_m1);
        sw_last = COL_BITS'(sw_m1);
        fy = (ry > {1'b0, sh_m1}) ? sh_last : ROW_BITS'(ry);
        fx = (rx > {1'b0, sw_m1}) ? sw_last : COL_BITS'(rx);
        cy = (!mode_reg || fy == sh_last) ? fy : fy + ROW_BITS'(1);
        cx = (!mode_reg || fx == sw_last) ? fx : fx + COL_BITS'(1);
        wy = mode_reg ? oy[FRAC_BITS-1:0] : '0;
        wx = mode_reg ? ox[FRAC_BITS-1:0] : '0;
    end

    logic                 vld_p1_reg;
    item_t                item_p1_reg;
    logic [ROW_BITS-1:0]  fy_reg, cy_reg;
    logic [COL_BITS-1:0]  fx_reg, cx_reg;
    logic [FRAC_BITS-1:0] wy_p1_reg, wx_p1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_p1_reg <= 1'b0;
        else
            vld_p1_reg <= vld_d_reg[Q_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        item_p1_reg <= item_d_reg[Q_BITS-1];
        fy_reg      <= fy;
        cy_reg      <= cy;
        fx_reg      <= fx;
        cx_reg      <= cx;
        wy_p1_reg   <= wy;
        wx_p1_reg   <= wx;
    end

    // frame store banks, split by row parity (upper index bit) and column parity
    logic                      bank_we    [NUM_BANKS];
    logic [BANK_ADDR_BITS-1:0] bank_waddr;
    logic [BANK_ADDR_BITS-1:0] bank_raddr [NUM_BANKS];
    pixel_t                    bank_rdata [NUM_BANKS];
    logic [ROW_BITS-1:0]       rd_row     [NUM_BANKS];
    logic [COL_BITS-1:0]       rd_col     [NUM_BANKS];
    logic                      is_write_p1;

    always_comb
    begin
        is_write_p1 = vld_p1_reg && (item_p1_reg.is_read == REQ_WRITE) && item_p1_reg.wr_ok;
        bank_waddr  = {item_p1_reg.row[ROW_BITS-1:1], item_p1_reg.col[COL_BITS-1:1]};
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bank_we[b] = is_write_p1 && (item_p1_reg.row[0] == b[1])
                                     && (item_p1_reg.col[0] == b[0]);
            rd_row[b]  = (fy_reg[0] == b[1]) ? fy_reg : cy_reg;
            rd_col[b]  = (fx_reg[0] == b[0]) ? fx_reg : cx_reg;
            bank_raddr[b] = {rd_row[b][ROW_BITS-1:1], rd_col[b][COL_BITS-1:1]};
        end
    end

    genvar gb;
    generate
        for (gb = 0; gb < NUM_BANKS; gb++)
        begin : g_bank
            rir_ram u_ram (
                .clk   (clk),
                .we    (bank_we[gb]),
                .waddr (bank_waddr),
                .wdata (item_p1_reg.pix),
                .raddr (bank_raddr[gb]),
                .rdata (bank_rdata[gb])
            );
        end
    endgenerate

    // hold selection info alongside the store read
    logic                 vld_p2_reg, read_p2_reg, range_p2_reg;
    logic                 fy0_reg, cy0_reg, fx0_reg, cx0_reg;
    logic [FRAC_BITS-1:0] wy_p2_reg, wx_p2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_p2_reg <= 1'b0;
        else
            vld_p2_reg <= vld_p1_reg;
    end

    always_ff @(posedge clk)
    begin
        read_p2_reg  <= item_p1_reg.is_read;
        range_p2_reg <= item_p1_reg.in_range;
        fy0_reg      <= fy_reg[0];
        cy0_reg      <= cy_reg[0];
        fx0_reg      <= fx_reg[0];
        cx0_reg      <= cx_reg[0];
        wy_p2_reg    <= wy_p1_reg;
        wx_p2_reg    <= wx_p1_reg;
    end

    // blend along each row
    pixel_t p11, p12, p21, p22, t1, t2;

    always_comb
    begin
        p11 = bank_rdata[{fy0_reg, fx0_reg}];
        p12 = bank_rdata[{fy0_reg, cx0_reg}];
        p21 = bank_rdata[{cy0_reg, fx0_reg}];
        p22 = bank_rdata[{cy0_reg, cx0_reg}];
        for (int k = 0; k < 4; k++)
        begin
            t1[8*k +: 8] = blend(p11[8*k +: 8], p12[8*k +: 8], wx_p2_reg);
            t2[8*k +: 8] = blend(p21[8*k +: 8], p22[8*k +: 8], wx_p2_reg);
        end
    end

    logic                 vld_p3_reg, read_p3_reg, range_p3_reg;
    pixel_t               t1_reg, t2_reg;
    logic [FRAC_BITS-1:0] wy_p3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_p3_reg <= 1'b0;
        else
            vld_p3_reg <= vld_p2_reg;
    end

    always_ff @(posedge clk)
    begin
        read_p3_reg  <= read_p2_reg;
        range_p3_reg <= range_p2_reg;
        t1_reg       <= t1;
        t2_reg       <= t2;
        wy_p3_reg    <= wy_p2_reg;
    end

    // blend the two rows, zero the pixel when out of range
    pixel_t pix_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            pix_next[8*k +: 8] = blend(t1_reg[8*k +: 8], t2_reg[8*k +: 8], wy_p3_reg);
        if (!range_p3_reg)
            pix_next = '0;
    end

    logic   strobe_reg, err_reg;
    pixel_t pix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= vld_p3_reg && (read_p3_reg == REQ_READ);
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        err_reg <= !range_p3_reg;
    end

    assign strobe      = strobe_reg;
    assign out_blue    = pix_reg[7:0];
    assign out_green   = pix_reg[15:8];
    assign out_red     = pix_reg[23:16];
    assign out_alpha   = pix_reg[31:24];
    assign range_error = err_reg;

    // a read transfer yields its result after the fixed latency
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type) |-> ##LATENCY strobe)
        else $error("read transfer produced no result");

    // a write transfer never yields a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !req_type) |-> ##LATENCY !strobe)
        else $error("write transfer produced a result");

    // an out-of-range result carries a zero pixel
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && range_error) |->
            (out_blue == 8'd0 && out_green == 8'd0 && out_red == 8'd0 && out_alpha == 8'd0))
        else $error("out-of-range result with non-zero pixel");

endmodule

`default_nettype wire

/* verif/tb_image_resize_interpolator.sv */
// Testbench for the image resize interpolator: directed and random transfers against a local predictor.
`timescale 1ns / 1ps

module tb_image_resize_interpolator;
    import rir_pkg::*;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       err;
    } pixel_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     req_type;
    logic [IDX_BITS-1:0]      row;
    logic [IDX_BITS-1:0]      col;
    logic [7:0]               in_blue;
    logic [7:0]               in_green;
    logic [7:0]               in_red;
    logic [7:0]               in_alpha;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     strobe;
    logic [7:0]               out_blue;
    logic [7:0]               out_green;
    logic [7:0]               out_red;
    logic [7:0]               out_alpha;
    logic                     range_error;

    // predictor state
    logic [31:0]   source_pixels [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
    bit            cell_written  [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
    int unsigned   pred_src_w, pred_src_h, pred_dst_w, pred_dst_h;
    logic          pred_bilinear;
    pixel_result_t pending_pixels [$];
    int            error_count;
    int            sender_idle_pct;

    image_resize_interpolator DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .row(row), .col(col),
        .in_blue(in_blue), .in_green(in_green), .in_red(in_red), .in_alpha(in_alpha),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .strobe(strobe), .out_blue(out_blue), .out_green(out_green),
        .out_red(out_red), .out_alpha(out_alpha), .range_error(range_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int unsigned eff_size(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic longint unsigned src_position(int unsigned idx, int unsigned s,
                                                     int unsigned d);
        longint unsigned num;
        if (d <= 1) return 0;
        num = (longint'(idx) * longint'(s - 1)) << FRAC_BITS;
        return num / longint'(d - 1);
    endfunction

    function automatic logic [7:0] mix(logic [7:0] p, logic [7:0] q, longint unsigned f);
        longint unsigned s;
        s = longint'(p) * ((64'd1 << FRAC_BITS) - f) + longint'(q) * f;
        return s[FRAC_BITS +: 8];
    endfunction

    function automatic pixel_result_t resize_pixel(int unsigned r, int unsigned c);
        pixel_result_t   res;
        int unsigned     sw, sh, dw, dh, ry, rx, cy, cx;
        longint unsigned oy, ox, wy, wx;
        logic [31:0]     p11, p12, p21, p22;
        logic [7:0]      t1, t2;
        sw = eff_size(pred_src_w, MAX_SRC_WIDTH);
        sh = eff_size(pred_src_h, MAX_SRC_HEIGHT);
        dw = eff_size(pred_dst_w, 8191);
        dh = eff_size(pred_dst_h, 8191);
        res = '{default: '0};
        if (r >= dh || c >= dw)
        begin
            res.err = 1'b1;
            return res;
        end
        oy = src_position(r, sh, dh);
        ox = src_position(c, sw, dw);
        if (!pred_bilinear)
        begin
            ry = (oy + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            rx = (ox + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (ry >= sh) ry = sh - 1;
            if (rx >= sw) rx = sw - 1;
            p11 = source_pixels[ry*MAX_SRC_WIDTH + rx];
            {res.alpha, res.red, res.green, res.blue} = p11;
            return res;
        end
        ry = oy >> FRAC_BITS;
        rx = ox >> FRAC_BITS;
        wy = oy & ((64'd1 << FRAC_BITS) - 1);
        wx = ox & ((64'd1 << FRAC_BITS) - 1);
        if (ry >= sh) ry = sh - 1;
        if (rx >= sw) rx = sw - 1;
        cy = (ry + 1 >= sh) ? ry : ry + 1;
        cx = (rx + 1 >= sw) ? rx : rx + 1;
        p11 = source_pixels[ry*MAX_SRC_WIDTH + rx];
        p12 = source_pixels[ry*MAX_SRC_WIDTH + cx];
        p21 = source_pixels[cy*MAX_SRC_WIDTH + rx];
        p22 = source_pixels[cy*MAX_SRC_WIDTH + cx];
        for (int k = 0; k < 4; k++)
        begin
            t1 = mix(p11[8*k +: 8], p12[8*k +: 8], wx);
            t2 = mix(p21[8*k +: 8], p22[8*k +: 8], wx);
            case (k)
                0: res.blue  = mix(t1, t2, wy);
                1: res.green = mix(t1, t2, wy);
                2: res.red   = mix(t1, t2, wy);
                default: res.alpha = mix(t1, t2, wy);
            endcase
        end
        return res;
    endfunction

    // source cells fetched by a read at (r, c); returns 0 for an out-of-range read
    function automatic bit read_cells(input int unsigned r, input int unsigned c,
                                      output int unsigned ry, output int unsigned rx,
                                      output int unsigned cy, output int unsigned cx);
        int unsigned     sw, sh, dw, dh;
        longint unsigned oy, ox;
        sw = eff_size(pred_src_w, MAX_SRC_WIDTH);
        sh = eff_size(pred_src_h, MAX_SRC_HEIGHT);
        dw = eff_size(pred_dst_w, 8191);
        dh = eff_size(pred_dst_h, 8191);
        ry = 0;
        rx = 0;
        cy = 0;
        cx = 0;
        if (r >= dh || c >= dw) return 1'b0;
        oy = src_position(r, sh, dh);
        ox = src_position(c, sw, dw);
        if (!pred_bilinear)
        begin
            ry = (oy + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            rx = (ox + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        end
        else
        begin
            ry = oy >> FRAC_BITS;
            rx = ox >> FRAC_BITS;
        end
        if (ry >= sh) ry = sh - 1;
        if (rx >= sw) rx = sw - 1;
        cy = (!pred_bilinear || ry + 1 >= sh) ? ry : ry + 1;
        cx = (!pred_bilinear || rx + 1 >= sw) ? rx : rx + 1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // compare each result with the oldest pending pixel
    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && strobe)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
                if (out_green !== want.green) report_mismatch("green", out_green, want.green);
                if (out_red !== want.red) report_mismatch("red", out_red, want.red);
                if (out_alpha !== want.alpha) report_mismatch("alpha", out_alpha, want.alpha);
                if (range_error !== want.err) report_mismatch("range_error", range_error, want.err);
            end
        end
    end

    // one transfer; start stays high afterwards unless the sender idles
    task automatic send_item(logic rt, logic [11:0] r, logic [11:0] c, logic [31:0] pix);
        start    <= 1'b1;
        req_type <= rt;
        row      <= r;
        col      <= c;
        {in_alpha, in_red, in_green, in_blue} <= pix;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (rt == REQ_WRITE)
        begin
            if (r < MAX_SRC_HEIGHT && c < MAX_SRC_WIDTH)
            begin
                source_pixels[r*MAX_SRC_WIDTH + c] = pix;
                cell_written[r*MAX_SRC_WIDTH + c]  = 1'b1;
            end
        end
        else
        begin
            pending_pixels.push_back(resize_pixel(r, c));
        end
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // write a source cell that holds no data yet
    task automatic fill_cell(int unsigned r, int unsigned c);
        if (!cell_written[r*MAX_SRC_WIDTH + c])
            send_item(REQ_WRITE, 12'(r), 12'(c), $urandom());
    endtask

    // one read transfer, after writing any cell it fetches that holds no data yet
    task automatic send_read(logic [11:0] r, logic [11:0] c);
        int unsigned ry, rx, cy, cx;
        if (read_cells(r, c, ry, rx, cy, cx))
        begin
            fill_cell(ry, rx);
            fill_cell(ry, cx);
            fill_cell(cy, rx);
            fill_cell(cy, cx);
        end
        send_item(REQ_READ, r, c, $urandom());
    endtask

    // hold off until nothing is in flight
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_config(int unsigned sw, int unsigned sh, int unsigned dw,
                                int unsigned dh, logic bil);
        logic [CFG_DATA_BITS-1:0] vals [5];
        logic [CFG_IDX_BITS-1:0]  idx [5];
        vals = '{sw, sh, dw, dh, bil};
        idx  = '{CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_DST_WIDTH, CFG_DST_HEIGHT,
                 CFG_INTERP_MODE};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        pred_src_w    = vals[0] & 13'h1FF;
        pred_src_h    = vals[1] & 13'h1FF;
        pred_dst_w    = vals[2];
        pred_dst_h    = vals[3];
        pred_bilinear = vals[4][0];
    endtask

    // fill a corner of the store; reads elsewhere write their cells first
    task automatic test_fill_and_defaults;
        sender_idle_pct = 0;
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                send_item(REQ_WRITE, 12'(r), 12'(c), $urandom());
        send_item(REQ_WRITE, 0, 0, 32'h0000_0000);
        send_item(REQ_WRITE, 255, 255, 32'hFFFF_FFFF);
        send_read(0, 0);
        send_read(255, 255);
        send_read(256, 0);
        send_read(0, 256);
        send_read(4095, 4095);
        drain();
    endtask

    // zero and oversized registers, dropped writes, both modes
    task automatic test_register_extremes;
        write_config(0, 300, 0, 8191, 1'b1);
        send_item(REQ_WRITE, 256, 3, 32'h1234_5678);
        send_item(REQ_WRITE, 4095, 4095, 32'hDEAD_BEEF);
        send_item(REQ_WRITE, 7, 256, 32'hCAFE_0001);
        send_read(0, 0);
        send_read(0, 1);
        send_read(4095, 0);
        send_read(1234, 0);
        drain();
        write_config(256, 1, 4096, 0, 1'b0);
        send_read(0, 4095);
        send_read(0, 2048);
        send_read(1, 0);
        drain();
        write_config(2, 2, 3, 3, 1'b1);
        send_read(1, 1);
        send_read(2, 2);
        send_read(3, 0);
        drain();
    endtask

    // random phases: small sizes mostly, the odd extreme
    task automatic test_random_traffic;
        int unsigned sw, sh, dw, dh, sent, ph, sel;
        logic [11:0] r, c;
        sent = 0;
        ph   = 0;
        while (sent < 600)
        begin
            sel = $urandom_range(9);
            sw  = (sel == 0) ? 256 : (sel == 1) ? 0 : (sel == 2) ? $urandom_range(257, 511)
                                 : $urandom_range(1, 12);
            sel = $urandom_range(9);
            sh  = (sel == 0) ? 256 : (sel == 1) ? 0 : $urandom_range(1, 12);
            sel = $urandom_range(9);
            dw  = (sel == 0) ? 4096 : (sel == 1) ? 0 : (sel == 2) ? 8191 : $urandom_range(1, 40);
            sel = $urandom_range(9);
            dh  = (sel == 0) ? 4096 : (sel == 1) ? 0 : $urandom_range(1, 40);
            write_config(sw, sh, dw, dh, $urandom_range(1));
            sender_idle_pct = (sent < 200) ? 16 : (sent < 400) ? 80 : 0;
            for (int i = 0; i < 50; i++)
            begin
                if ($urandom_range(9) < 3)
                begin
                    r = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 15);
                    c = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 15);
                    send_item(REQ_WRITE, r, c, $urandom());
                end
                else
                begin
                    r = ($urandom_range(7) == 0) ? $urandom()
                        : $urandom_range(0, eff_size(dh, 4096) - 1);
                    c = ($urandom_range(7) == 0) ? $urandom()
                        : $urandom_range(0, eff_size(dw, 4096) - 1);
                    send_read(r, c);
                end
                sent++;
            end
            ph++;
            drain();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req_type  = REQ_WRITE;
        row       = '0;
        col       = '0;
        in_blue   = '0;
        in_green  = '0;
        in_red    = '0;
        in_alpha  = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SRC_WIDTH;
        cfg_data  = '0;
        error_count     = 0;
        sender_idle_pct = 0;
        pred_src_w      = 256;
        pred_src_h      = 256;
        pred_dst_w      = 256;
        pred_dst_h      = 256;
        pred_bilinear   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_fill_and_defaults();
        test_register_extremes();
        test_random_traffic();
        drain();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
